[rtl/core/wgm_pkg.sv]
// Package of shared constants, types and the control store of the wildcard glob matcher.
package wgm_pkg;

  // Store capacity and the widths that follow from it.
  localparam int MAX_LEN = 256;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int LW      = AW + 1;

  // Request opcodes.
  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_EVAL    = 2'd2;

  // Pattern symbols and the string terminator.
  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;
  localparam logic [7:0] SYM_END     = 8'h00;

  // Sequencer steps.
  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_OVF_CHK   = 4'd1,
    ST_TEXT_CHK  = 4'd2,
    ST_COMPARE   = 4'd3,
    ST_TAIL_CHK  = 4'd4,
    ST_TAIL_SKIP = 4'd5,
    ST_RPT_MISS  = 4'd6,
    ST_RPT_HIT   = 4'd7,
    ST_RPT_OVF   = 4'd8
  } step_t;

  // Datapath actions selected by a control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INIT,
    ACT_STEP,
    ACT_SKIP,
    ACT_RPT_MISS,
    ACT_RPT_HIT,
    ACT_RPT_OVF
  } act_t;

  // Branch conditions tested by a control word.
  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_EVAL,
    CND_OVF,
    CND_TEXT_DONE,
    CND_MISMATCH,
    CND_PAT_END,
    CND_NOT_STAR,
    CND_OUT_FREE
  } cond_t;

  // One control word: action, condition, target when taken, target otherwise.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_t;

  // Read-only control store.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      ST_IDLE:      w = '{ACT_LOAD,     CND_EVAL,      ST_OVF_CHK,  ST_IDLE};
      ST_OVF_CHK:   w = '{ACT_INIT,     CND_OVF,       ST_RPT_OVF,  ST_TEXT_CHK};
      ST_TEXT_CHK:  w = '{ACT_NONE,     CND_TEXT_DONE, ST_TAIL_CHK, ST_COMPARE};
      ST_COMPARE:   w = '{ACT_STEP,     CND_MISMATCH,  ST_RPT_MISS, ST_TEXT_CHK};
      ST_TAIL_CHK:  w = '{ACT_NONE,     CND_PAT_END,   ST_RPT_HIT,  ST_TAIL_SKIP};
      ST_TAIL_SKIP: w = '{ACT_SKIP,     CND_NOT_STAR,  ST_RPT_MISS, ST_TAIL_CHK};
      ST_RPT_MISS:  w = '{ACT_RPT_MISS, CND_OUT_FREE,  ST_IDLE,     ST_RPT_MISS};
      ST_RPT_HIT:   w = '{ACT_RPT_HIT,  CND_OUT_FREE,  ST_IDLE,     ST_RPT_HIT};
      ST_RPT_OVF:   w = '{ACT_RPT_OVF,  CND_OUT_FREE,  ST_IDLE,     ST_RPT_OVF};
      default:      w = '{ACT_NONE,     CND_ALWAYS,    ST_IDLE,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/wgm_if.sv]
// Request and result channel interfaces of the wildcard glob matcher.
interface wgm_in_if
  import wgm_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface wgm_out_if
  import wgm_pkg::*;
();
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, output matched, output overflowed, input ready);
  modport sink   (input valid, input matched, input overflowed, output ready);
endinterface

[rtl/core/wgm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/wildcard_glob_matcher_unit.sv]
// Top level of the wildcard glob matcher: stores, microcoded sequencer and result register.
//
//  channel   dir  signals                          request meaning
//  in_chan   in   valid ready opcode byte_value    append pattern or text byte, or evaluate
//  out_chan  out  valid ready matched overflowed   verdict of one evaluation
//
//  Append requests are taken back to back while idle.
//  An evaluation does the overflow check, then compare steps (store read, then compare),
//  the trailing star skips, the final checks and the report, or only the overflow check
//  and report on overflow; backtracking repeats compare steps.
//  rst_n is synchronous and active low; it empties both stores at once.
//  Requests stall during evaluation; the verdict waits in the output register.
module wildcard_glob_matcher_unit
  import wgm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  wgm_in_if.sink    in_chan,
  wgm_out_if.source out_chan
);

  // Sequencer and store state.
  step_t          step_r, step_nxt;
  logic [LW-1:0]  plen_r, plen_nxt;
  logic [LW-1:0]  tlen_r, tlen_nxt;
  logic           ovf_r, ovf_nxt;
  logic [LW-1:0]  ti_r, ti_nxt;
  logic [LW-1:0]  pi_r, pi_nxt;
  logic [LW-1:0]  star_at_r, star_at_nxt;
  logic [LW-1:0]  resume_at_r, resume_at_nxt;
  logic           have_star_r, have_star_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           matched_r, matched_nxt;
  logic           overflowed_r, overflowed_nxt;

  ucode_t         uw;
  logic           cond_hit;
  logic           in_take;
  logic           out_free;
  logic           pat_we;
  logic           txt_we;
  logic [7:0]     pat_q;
  logic [7:0]     txt_q;
  logic           p_live;
  logic           sym_hit;
  logic           star_here;

  // Handshake status.
  assign in_chan.ready = (step_r == ST_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Compare terms on the bytes read at the current positions.
  assign p_live    = (pi_r < plen_r);
  assign sym_hit   = p_live && ((pat_q == txt_q) || (pat_q == SYM_ANY_ONE));
  assign star_here = p_live && (pat_q == SYM_ANY_RUN);

  // Pattern and text stores.
  wgm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (plen_r[AW-1:0]),
    .wdata (in_chan.byte_value),
    .raddr (pi_r[AW-1:0]),
    .rdata (pat_q)
  );

  wgm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_txt_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (tlen_r[AW-1:0]),
    .wdata (in_chan.byte_value),
    .raddr (ti_r[AW-1:0]),
    .rdata (txt_q)
  );

  // Step register and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      plen_r      <= '0;
      tlen_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      plen_r      <= plen_nxt;
      tlen_r      <= tlen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ti_r         <= ti_nxt;
    pi_r         <= pi_nxt;
    star_at_r    <= star_at_nxt;
    resume_at_r  <= resume_at_nxt;
    have_star_r  <= have_star_nxt;
    matched_r    <= matched_nxt;
    overflowed_r <= overflowed_nxt;
  end

  // Control word decode: branch condition, datapath action and next step.
  always_comb begin
    uw             = ucode_rom(step_r);
    plen_nxt       = plen_r;
    tlen_nxt       = tlen_r;
    ovf_nxt        = ovf_r;
    ti_nxt         = ti_r;
    pi_nxt         = pi_r;
    star_at_nxt    = star_at_r;
    resume_at_nxt  = resume_at_r;
    have_star_nxt  = have_star_r;
    matched_nxt    = matched_r;
    overflowed_nxt = overflowed_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    pat_we         = 1'b0;
    txt_we         = 1'b0;

    // Branch condition.
    case (uw.cond)
      CND_ALWAYS:    cond_hit = 1'b1;
      CND_EVAL:      cond_hit = in_take && (in_chan.opcode == OP_EVAL);
      CND_OVF:       cond_hit = ovf_r;
      CND_TEXT_DONE: cond_hit = (ti_r >= tlen_r);
      CND_MISMATCH:  cond_hit = !sym_hit && !star_here && !have_star_r;
      CND_PAT_END:   cond_hit = (pi_r >= plen_r);
      CND_NOT_STAR:  cond_hit = (pat_q != SYM_ANY_RUN);
      CND_OUT_FREE:  cond_hit = out_free;
      default:       cond_hit = 1'b1;
    endcase

    // Datapath action.
    case (uw.act)
      ACT_LOAD: begin
        // Append a non-zero byte, or flag overflow when the store is full.
        if (in_take && (in_chan.byte_value != SYM_END)) begin
          if (in_chan.opcode == OP_PATTERN) begin
            if (plen_r == LW'(MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              pat_we   = 1'b1;
              plen_nxt = plen_r + 1'b1;
            end
          end else if (in_chan.opcode == OP_TEXT) begin
            if (tlen_r == LW'(MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              txt_we   = 1'b1;
              tlen_nxt = tlen_r + 1'b1;
            end
          end
        end
      end
      ACT_INIT: begin
        ti_nxt        = '0;
        pi_nxt        = '0;
        have_star_nxt = 1'b0;
      end
      ACT_STEP: begin
        // Advance both on a match, note a star, or retry from the last star.
        if (sym_hit) begin
          ti_nxt = ti_r + 1'b1;
          pi_nxt = pi_r + 1'b1;
        end else if (star_here) begin
          have_star_nxt = 1'b1;
          star_at_nxt   = pi_r;
          resume_at_nxt = ti_r;
          pi_nxt        = pi_r + 1'b1;
        end else if (have_star_r) begin
          resume_at_nxt = resume_at_r + 1'b1;
          ti_nxt        = resume_at_r + 1'b1;
          pi_nxt        = star_at_r + 1'b1;
        end
      end
      ACT_SKIP: begin
        if (pat_q == SYM_ANY_RUN) begin
          pi_nxt = pi_r + 1'b1;
        end
      end
      ACT_RPT_MISS, ACT_RPT_HIT, ACT_RPT_OVF: begin
        // Load the verdict once the output register is free and empty the stores.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          matched_nxt    = (uw.act == ACT_RPT_HIT);
          overflowed_nxt = (uw.act == ACT_RPT_OVF);
          plen_nxt       = '0;
          tlen_nxt       = '0;
          ovf_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase

    step_nxt = cond_hit ? uw.jump : uw.next;
  end

  // Result channel.
  assign out_chan.valid      = out_valid_r;
  assign out_chan.matched    = matched_r;
  assign out_chan.overflowed = overflowed_r;

`ifndef ASSERT_OFF
  // An overflowed verdict never reports a match.
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(matched_r && overflowed_r))
    else $error("overflow reported together with a match");

  // Store lengths never pass the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r <= LW'(MAX_LEN)) && (tlen_r <= LW'(MAX_LEN)))
    else $error("store length beyond capacity");

  // A compare step only ever sees a text position inside the text.
  a_ti_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_COMPARE) |-> (ti_r < tlen_r))
    else $error("compare step past the end of the text");

  // An accepted evaluate request starts the sequence.
  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_chan.opcode == OP_EVAL)) |=> (step_r == ST_OVF_CHK))
    else $error("evaluate request did not start the sequence");

  // A delivered verdict leaves both stores empty and the overflow flag clear.
  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (((step_r == ST_RPT_MISS) || (step_r == ST_RPT_HIT) || (step_r == ST_RPT_OVF))
      && out_free) |=> ((plen_r == '0) && (tlen_r == '0) && !ovf_r && out_valid_r))
    else $error("stores not emptied after a verdict");
`endif

endmodule
